### rtl/rsd_pkg.sv
// Shared types, register numbers, decode phases and flag-bit selection for the
// packed sound-register stream decoder. No dependencies.
package rsd_pkg;

    localparam int TONE_CHANNELS = 3;

    localparam int RESTART_BIT = 7;
    localparam int BATCH_MAX   = 4;

    // flag-byte bit positions
    localparam int MIXER_BIT = 7;
    localparam int ENV_BIT   = 6 - TONE_CHANNELS;
    localparam int LEVA_BIT  = 5 - TONE_CHANNELS;
    localparam int LEVB_BIT  = 4 - TONE_CHANNELS;
    localparam int LEVC_BIT  = 3 - TONE_CHANNELS;
    localparam logic [7:0] FLAG_MASK = 8'(32'h0000_00FF << (3 - TONE_CHANNELS));

    // decode phases
    localparam logic [3:0] PH_FLAG   = 4'd0;
    localparam logic [3:0] PH_MIXER  = 4'd1;
    localparam logic [3:0] PH_TONE_L = 4'd2;
    localparam logic [3:0] PH_TONE_H = 4'd3;
    localparam logic [3:0] PH_ENV_L  = 4'd4;
    localparam logic [3:0] PH_ENV_H  = 4'd5;
    localparam logic [3:0] PH_LEVA   = 4'd6;
    localparam logic [3:0] PH_NOISE  = 4'd7;
    localparam logic [3:0] PH_LEVB   = 4'd8;
    localparam logic [3:0] PH_SHAPE  = 4'd9;
    localparam logic [3:0] PH_LEVC   = 4'd10;

    // sound chip registers
    localparam logic [3:0] R_NOISE = 4'd6;
    localparam logic [3:0] R_MIXER = 4'd7;
    localparam logic [3:0] R_LEVA  = 4'd8;
    localparam logic [3:0] R_LEVB  = 4'd9;
    localparam logic [3:0] R_LEVC  = 4'd10;
    localparam logic [3:0] R_ENVL  = 4'd11;
    localparam logic [3:0] R_ENVH  = 4'd12;
    localparam logic [3:0] R_SHAPE = 4'd13;

    typedef struct packed {
        logic       is_write;
        logic [3:0] reg_index;
        logic [7:0] reg_value;
        logic       frame_done;
        logic       last;
    } rsd_result_t;

    typedef struct packed {
        logic                            any;
        rsd_result_t [BATCH_MAX-1:0]     res;
    } rsd_batch_t;

    typedef struct packed {
        logic       found;
        logic       tone;
        logic [1:0] channel;
        logic [3:0] phase;
        logic [7:0] pending;
    } rsd_pick_t;

    // next selected item of the frame, highest flag bit first
    function automatic rsd_pick_t rsd_pick_next(input logic [7:0] pend);
        rsd_pick_t  p;
        logic [7:0] rest;
        logic       hit;
        p     = '0;
        rest  = pend;
        hit   = 1'b0;
        p.phase = PH_FLAG;
        if (rest[MIXER_BIT]) begin
            hit = 1'b1;
            rest[MIXER_BIT] = 1'b0;
            p.phase = PH_MIXER;
        end
        for (int c = 0; c < TONE_CHANNELS; c++) begin
            if (!hit && rest[6-c]) begin
                hit = 1'b1;
                rest[6-c] = 1'b0;
                p.phase = PH_TONE_L;
                p.tone = 1'b1;
                p.channel = 2'(c);
            end
        end
        if (!hit && rest[ENV_BIT]) begin
            hit = 1'b1;
            rest[ENV_BIT] = 1'b0;
            p.phase = PH_ENV_L;
        end
        if (!hit && rest[LEVA_BIT]) begin
            hit = 1'b1;
            rest[LEVA_BIT] = 1'b0;
            p.phase = PH_LEVA;
        end
        if (!hit && rest[LEVB_BIT]) begin
            hit = 1'b1;
            rest[LEVB_BIT] = 1'b0;
            p.phase = PH_LEVB;
        end
        if (!hit && rest[LEVC_BIT]) begin
            hit = 1'b1;
            rest[LEVC_BIT] = 1'b0;
            p.phase = PH_LEVC;
        end
        p.found   = hit;
        p.pending = rest;
        return p;
    endfunction

endpackage

### rtl/rsd_decoder.sv
// Frame decoder: holds the frame state and turns one stream word into a batch
// of up to four register writes, or a frame-done marker. Depends on rsd_pkg.
module rsd_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          in_byte,
    output rsd_pkg::rsd_batch_t batch
);
    import rsd_pkg::*;

    logic [3:0] phase_reg, phase_next;
    logic [7:0] pending_reg, pending_next;
    logic [1:0] channel_reg, channel_next;
    logic [7:0] held_reg, held_next;

    rsd_result_t [BATCH_MAX-1:0] res;
    logic [2:0]  n;
    logic        done;
    logic        do_pick;
    logic [7:0]  pick_src;
    rsd_pick_t   pk;
    logic [3:0]  tone_lo;
    logic [3:0]  tone_hi;

    assign tone_lo = {1'b0, channel_reg, 1'b0};
    assign tone_hi = {1'b0, channel_reg, 1'b1};

    always_comb begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        channel_next = channel_reg;
        held_next    = held_reg;
        res          = '0;
        n            = 3'd0;
        done         = 1'b0;
        do_pick      = 1'b0;
        pick_src     = pending_reg;
        case (phase_reg)
            PH_MIXER: begin
                res[0] = '{1'b1, R_MIXER, in_byte, 1'b0, 1'b0};
                n = 3'd1;
                do_pick = 1'b1;
            end
            PH_TONE_L: begin
                held_next  = in_byte;
                phase_next = PH_TONE_H;
            end
            PH_TONE_H: begin
                if (in_byte[RESTART_BIT]) begin
                    res[0] = '{1'b1, tone_lo, 8'h00, 1'b0, 1'b0};
                    res[1] = '{1'b1, tone_hi, 8'h00, 1'b0, 1'b0};
                    res[2] = '{1'b1, tone_lo, held_reg, 1'b0, 1'b0};
                    res[3] = '{1'b1, tone_hi, in_byte, 1'b0, 1'b0};
                    n = 3'd4;
                end else begin
                    res[0] = '{1'b1, tone_lo, held_reg, 1'b0, 1'b0};
                    res[1] = '{1'b1, tone_hi, in_byte, 1'b0, 1'b0};
                    n = 3'd2;
                end
                do_pick = 1'b1;
            end
            PH_ENV_L: begin
                held_next  = in_byte;
                phase_next = PH_ENV_H;
            end
            PH_ENV_H: begin
                res[0] = '{1'b1, R_ENVL, held_reg, 1'b0, 1'b0};
                res[1] = '{1'b1, R_ENVH, in_byte, 1'b0, 1'b0};
                n = 3'd2;
                do_pick = 1'b1;
            end
            PH_LEVA: begin
                if (in_byte[RESTART_BIT]) begin
                    held_next  = in_byte;
                    phase_next = PH_NOISE;
                end else begin
                    res[0] = '{1'b1, R_LEVA, in_byte, 1'b0, 1'b0};
                    n = 3'd1;
                    do_pick = 1'b1;
                end
            end
            PH_NOISE: begin
                res[0] = '{1'b1, R_NOISE, in_byte, 1'b0, 1'b0};
                res[1] = '{1'b1, R_LEVA, held_reg, 1'b0, 1'b0};
                n = 3'd2;
                do_pick = 1'b1;
            end
            PH_LEVB: begin
                if (in_byte[RESTART_BIT]) begin
                    held_next  = in_byte;
                    phase_next = PH_SHAPE;
                end else begin
                    res[0] = '{1'b1, R_LEVB, in_byte, 1'b0, 1'b0};
                    n = 3'd1;
                    do_pick = 1'b1;
                end
            end
            PH_SHAPE: begin
                res[0] = '{1'b1, R_SHAPE, in_byte, 1'b0, 1'b0};
                res[1] = '{1'b1, R_LEVB, held_reg, 1'b0, 1'b0};
                n = 3'd2;
                do_pick = 1'b1;
            end
            PH_LEVC: begin
                res[0] = '{1'b1, R_LEVC, in_byte, 1'b0, 1'b0};
                n = 3'd1;
                do_pick = 1'b1;
            end
            default: begin
                pick_src = in_byte & FLAG_MASK;
                do_pick  = 1'b1;
            end
        endcase

        pk = rsd_pick_next(pick_src);

        if (do_pick) begin
            pending_next = pk.pending;
            phase_next   = pk.phase;
            if (pk.tone) begin
                channel_next = pk.channel;
            end
            if (!pk.found) begin
                done = 1'b1;
                // empty flag word: marker only
                if (phase_reg == PH_FLAG || !(phase_reg inside {PH_MIXER, PH_TONE_L,
                        PH_TONE_H, PH_ENV_L, PH_ENV_H, PH_LEVA, PH_NOISE, PH_LEVB,
                        PH_SHAPE, PH_LEVC})) begin
                    res[0] = '0;
                    n = 3'd1;
                end
            end
        end

        for (int i = 0; i < BATCH_MAX; i++) begin
            if (n == 3'(i + 1)) begin
                res[i].last       = 1'b1;
                res[i].frame_done = done;
            end
        end
    end

    assign batch.any = (n != 3'd0);
    assign batch.res = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FLAG;
            pending_reg <= 8'h00;
            channel_reg <= 2'd0;
            held_reg    <= 8'h00;
        end else if (in_accept) begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            channel_reg <= channel_next;
            held_reg    <= held_next;
        end
    end

endmodule

### rtl/rsd_out_buffer.sv
// Result register: holds one word's batch of writes and hands them out one per
// cycle on the result channel while out_ready is high. Depends on rsd_pkg.
module rsd_out_buffer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  rsd_pkg::rsd_batch_t  batch,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsd_pkg::rsd_result_t out_res
);
    import rsd_pkg::*;

    rsd_result_t [BATCH_MAX-1:0] res_reg;
    logic                        valid_reg;
    logic [1:0]                  ptr_reg;
    logic                        take;

    assign out_res   = res_reg[ptr_reg];
    assign out_valid = valid_reg;
    assign take      = valid_reg && out_ready;
    assign free      = !valid_reg || (out_ready && out_res.last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ptr_reg   <= 2'd0;
        end else if (load && batch.any) begin
            valid_reg <= 1'b1;
            ptr_reg   <= 2'd0;
        end else if (take) begin
            if (out_res.last) begin
                valid_reg <= 1'b0;
                ptr_reg   <= 2'd0;
            end else begin
                ptr_reg <= ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && batch.any) begin
            res_reg <= batch.res;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !valid_reg)
        else $error("result register not empty after reset");
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && out_res.frame_done |-> out_res.last)
        else $error("frame end on a word that is not the last of its batch");
    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_res.is_write |-> out_res.frame_done && ptr_reg == 2'd0)
        else $error("malformed frame marker");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(ptr_reg))
        else $error("result moved while stalled");

endmodule

### rtl/ym_register_stream_decoder.sv
// Top level of the packed sound-register stream decoder.
// Depends on rsd_pkg, rsd_decoder and rsd_out_buffer.
//
//  channel | ports                                   | word
//  --------+-----------------------------------------+------------------------------
//  input   | s_valid s_ready s_byte_in               | one byte of the packed stream
//  result  | m_valid m_ready m_is_write m_reg_index  | one register write or a
//          | m_reg_value m_frame_done m_last         | frame-done marker
//
// A byte is decoded in the cycle it is accepted; its writes appear from the
// next cycle, one per cycle from the result register while m_ready is high.
// s_ready is high while the result register is empty or giving out its last word.
// aresetn (synchronous) returns the decoder to expecting a flag byte.
module ym_register_stream_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_write,
    output logic [3:0] m_reg_index,
    output logic [7:0] m_reg_value,
    output logic       m_frame_done,
    output logic       m_last
);
    import rsd_pkg::*;

    rsd_batch_t  batch;
    rsd_result_t res;
    logic        accept;
    logic        free;

    assign s_ready = free;
    assign accept  = s_valid && free;

    rsd_decoder u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_byte   (s_byte_in),
        .batch     (batch)
    );

    rsd_out_buffer u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .batch     (batch),
        .free      (free),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_is_write   = res.is_write;
    assign m_reg_index  = res.reg_index;
    assign m_reg_value  = res.reg_value;
    assign m_frame_done = res.frame_done;
    assign m_last       = res.last;

endmodule

### tb/rsd_write_checker.sv
`timescale 1ns / 1ps
// Write checker for the packed sound-register stream decoder: follows each accepted byte,
// works out the register writes and frame markers it causes, and compares every result word.
// Depends on rsd_pkg.
module rsd_write_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_is_write,
    input  logic [3:0] m_reg_index,
    input  logic [7:0] m_reg_value,
    input  logic       m_frame_done,
    input  logic       m_last,
    output int         fail_count,
    output int         outstanding
);
    import rsd_pkg::*;

    logic [3:0]  phase         = PH_FLAG;
    logic [7:0]  pending_flags = '0;
    logic [1:0]  channel       = '0;
    logic [7:0]  held_byte     = '0;
    rsd_result_t expected_writes[$];
    rsd_result_t byte_writes[$];
    int          errors        = 0;

    task automatic add_write(input logic w, input logic [3:0] r, input logic [7:0] v);
        rsd_result_t x;
        x           = '0;
        x.is_write  = w;
        x.reg_index = r;
        x.reg_value = v;
        byte_writes.push_back(x);
    endtask

    // start the highest selected item still pending; frame_over when none is left
    task automatic claim_next(output logic frame_over);
        logic hit;
        int   c;
        hit = 1'b0;
        if (pending_flags[MIXER_BIT]) begin
            pending_flags[MIXER_BIT] = 1'b0;
            phase = PH_MIXER;
            hit = 1'b1;
        end
        for (c = 0; c < TONE_CHANNELS; c++) begin
            if (!hit && pending_flags[6-c]) begin
                pending_flags[6-c] = 1'b0;
                phase = PH_TONE_L;
                channel = 2'(c);
                hit = 1'b1;
            end
        end
        if (!hit && pending_flags[ENV_BIT]) begin
            pending_flags[ENV_BIT] = 1'b0;
            phase = PH_ENV_L;
            hit = 1'b1;
        end
        if (!hit && pending_flags[LEVA_BIT]) begin
            pending_flags[LEVA_BIT] = 1'b0;
            phase = PH_LEVA;
            hit = 1'b1;
        end
        if (!hit && pending_flags[LEVB_BIT]) begin
            pending_flags[LEVB_BIT] = 1'b0;
            phase = PH_LEVB;
            hit = 1'b1;
        end
        if (!hit && pending_flags[LEVC_BIT]) begin
            pending_flags[LEVC_BIT] = 1'b0;
            phase = PH_LEVC;
            hit = 1'b1;
        end
        if (!hit)
            phase = PH_FLAG;
        frame_over = !hit;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic        done;
        rsd_result_t x;
        done = 1'b0;
        byte_writes.delete();
        case (phase)
            PH_MIXER: begin
                add_write(1'b1, R_MIXER, b);
                claim_next(done);
            end
            PH_TONE_L: begin
                held_byte = b;
                phase = PH_TONE_H;
            end
            PH_TONE_H: begin
                if (b[RESTART_BIT]) begin
                    add_write(1'b1, {1'b0, channel, 1'b0}, 8'h00);
                    add_write(1'b1, {1'b0, channel, 1'b1}, 8'h00);
                end
                add_write(1'b1, {1'b0, channel, 1'b0}, held_byte);
                add_write(1'b1, {1'b0, channel, 1'b1}, b);
                claim_next(done);
            end
            PH_ENV_L: begin
                held_byte = b;
                phase = PH_ENV_H;
            end
            PH_ENV_H: begin
                add_write(1'b1, R_ENVL, held_byte);
                add_write(1'b1, R_ENVH, b);
                claim_next(done);
            end
            PH_LEVA: begin
                if (b[RESTART_BIT]) begin
                    held_byte = b;
                    phase = PH_NOISE;
                end else begin
                    add_write(1'b1, R_LEVA, b);
                    claim_next(done);
                end
            end
            PH_NOISE: begin
                add_write(1'b1, R_NOISE, b);
                add_write(1'b1, R_LEVA, held_byte);
                claim_next(done);
            end
            PH_LEVB: begin
                if (b[RESTART_BIT]) begin
                    held_byte = b;
                    phase = PH_SHAPE;
                end else begin
                    add_write(1'b1, R_LEVB, b);
                    claim_next(done);
                end
            end
            PH_SHAPE: begin
                add_write(1'b1, R_SHAPE, b);
                add_write(1'b1, R_LEVB, held_byte);
                claim_next(done);
            end
            PH_LEVC: begin
                add_write(1'b1, R_LEVC, b);
                claim_next(done);
            end
            default: begin
                pending_flags = b & FLAG_MASK;
                claim_next(done);
                if (done)
                    add_write(1'b0, 4'd0, 8'h00);
            end
        endcase
        if (byte_writes.size() > 0) begin
            x = byte_writes.pop_back();
            x.last = 1'b1;
            x.frame_done = done;
            byte_writes.push_back(x);
        end
        foreach (byte_writes[i])
            expected_writes.push_back(byte_writes[i]);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : watch
        rsd_result_t want;
        if (!aresetn) begin
            phase = PH_FLAG;
            pending_flags = '0;
            channel = '0;
            held_byte = '0;
            expected_writes.delete();
        end else begin
            // words out of the block belong to earlier bytes, so retire them first
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    $error("unexpected word: is_write %0d reg_index %0d reg_value %0h",
                           m_is_write, m_reg_index, m_reg_value);
                    errors++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("is_write", 32'(want.is_write), 32'(m_is_write));
                    check_field("reg_index", 32'(want.reg_index), 32'(m_reg_index));
                    check_field("reg_value", 32'(want.reg_value), 32'(m_reg_value));
                    check_field("frame_done", 32'(want.frame_done), 32'(m_frame_done));
                    check_field("last", 32'(want.last), 32'(m_last));
                end
            end
            if (s_valid && s_ready)
                decode_byte(s_byte_in);
        end
        fail_count <= errors;
        outstanding <= expected_writes.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for ym_register_stream_decoder: clock, reset, byte stimulus,
// random result back-pressure, watchdog and verdict. Depends on rsd_pkg and rsd_write_checker.
module tb;
    import rsd_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int BYTE_COUNT = 470;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_byte_in;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_is_write;
    logic [3:0] m_reg_index;
    logic [7:0] m_reg_value;
    logic       m_frame_done;
    logic       m_last;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;
    int ready_hold  = 0;
    int bytes_sent  = 0;
    int frame_no    = 0;
    bit burst       = 1'b0;

    logic [7:0] directed_bytes [26] = '{
        8'h00,
        8'hFF, 8'h3F, 8'h34, 8'h81, 8'hFF, 8'h0F, 8'h00, 8'hFF,
        8'h12, 8'hFF, 8'h9F, 8'h1F, 8'h90, 8'h0E, 8'h0F,
        8'h06, 8'h0A, 8'h7F,
        8'h11, 8'hAA, 8'h55, 8'h00,
        8'h08, 8'h00, 8'h00
    };

    always #5 aclk = ~aclk;

    ym_register_stream_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_write   (m_is_write),
        .m_reg_index  (m_reg_index),
        .m_reg_value  (m_reg_value),
        .m_frame_done (m_frame_done),
        .m_last       (m_last)
    );

    rsd_write_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_write   (m_is_write),
        .m_reg_index  (m_reg_index),
        .m_reg_value  (m_reg_value),
        .m_frame_done (m_frame_done),
        .m_last       (m_last),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // receiver: runs of ready, mostly short stalls, now and then a long one
    always @(posedge aclk) begin : sink
        int r;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_ready <= 1'b1;
                ready_hold <= $urandom_range(0, 15);
            end else if (r < 95) begin
                m_ready <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b0;
                ready_hold <= $urandom_range(10, 30);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // holds valid until the word is taken; lowers it only if a gap follows
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_valid <= 1'b1;
        s_byte_in <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // flag byte, then random content for every item it selects
    task automatic send_frame();
        logic [7:0] flags;
        logic [7:0] b;
        int         c;
        flags = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        send_byte(flags);
        flags = flags & FLAG_MASK;
        if (flags[MIXER_BIT])
            send_byte(8'($urandom));
        for (c = 0; c < TONE_CHANNELS; c++) begin
            if (flags[6-c]) begin
                send_byte(8'($urandom));
                send_byte(8'($urandom));
            end
        end
        if (flags[ENV_BIT]) begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
        end
        if (flags[LEVA_BIT]) begin
            b = 8'($urandom);
            send_byte(b);
            if (b[RESTART_BIT])
                send_byte(8'($urandom));
        end
        if (flags[LEVB_BIT]) begin
            b = 8'($urandom);
            send_byte(b);
            if (b[RESTART_BIT])
                send_byte(8'($urandom));
        end
        if (flags[LEVC_BIT])
            send_byte(8'($urandom));
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_byte_in = 8'h00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        drain_results();

        while (bytes_sent < BYTE_COUNT) begin
            burst = ($urandom_range(0, 3) == 0);
            // stray bytes knock the stream out of frame alignment
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom));
            end
            send_frame();
            frame_no++;
            if (frame_no == 25)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
